@@ hdl/svt_pkg.sv @@
package svt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_CONTAINS = 2'd2;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [DATA_W-1:0] item_value;
   } svt_req_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] entry_count;
      logic       overflow;
   } svt_rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } svt_mem_type;

   typedef struct packed {
      logic        valid;
      svt_rsp_type rsp;
   } svt_done_type;

endpackage

@@ hdl/sorted_value_table.sv @@
// Channel   Ports                        Beat taken when
// request   start, busy, req_item        start && !busy at a rising edge
// response  rsp_valid, rsp_item          every cycle rsp_valid is high
//
// Insert on a non-empty table walks down from the top entry through the single
// compare unit until an entry is not above the value, then writes the value;
// on an empty table it writes the value directly. Remove and contains read
// every entry, one table read per cycle. Full insert, unused opcode and empty
// remove/contains go straight to the result.
// The table RAM has one write and one registered read port; the walk is
// pipelined one read per cycle. Result strobe follows the last busy cycle.
// Reset clears the entry count; table contents need no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_value_table import svt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  svt_req_type req_item,
   output logic        rsp_valid,
   output svt_rsp_type rsp_item
);

   svt_mem_type       mem;
   svt_done_type      done;
   logic [DATA_W-1:0] rd_data;
   logic              rsp_valid_ff;
   svt_rsp_type       rsp_item_ff;

   svt_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .rd_data  (rd_data),
      .busy     (busy),
      .mem      (mem),
      .done     (done)
   );

   svt_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= done.rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back response strobes");

   a_hit_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.hit && rsp_item.overflow))
      else $error("hit and overflow both set");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.overflow |-> rsp_item.entry_count == 5'(TABLE_DEPTH))
      else $error("overflow reported with table not full");
`endif

endmodule

@@ hdl/svt_ram.sv @@
module svt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/svt_engine.sv @@
module svt_engine import svt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  svt_req_type       req_item,
   input  logic [DATA_W-1:0] rd_data,
   output logic              busy,
   output svt_mem_type       mem,
   output svt_done_type      done
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_PLACE = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [DATA_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [ADDR_W-1:0] place_ff, place_in;
   logic              hit_ff, hit_in;
   logic              ovf_ff, ovf_in;

   // shared comparator
   logic gt, eq, last;
   assign gt   = $signed(rd_data) > $signed(word_ff);
   assign eq   = rd_data == word_ff;
   assign last = pend_ff && (issue_ff == '0);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      word_in  = word_ff;
      fill_in  = fill_ff;
      issue_in = issue_ff;
      raddr_in = raddr_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      wr_in    = wr_ff;
      place_in = place_ff;
      hit_in   = hit_ff;
      ovf_in   = ovf_ff;
      mem      = '0;
      done     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_item.opcode;
               word_in  = req_item.item_value;
               hit_in   = 1'b0;
               ovf_in   = 1'b0;
               pend_in  = 1'b0;
               wr_in    = '0;
               state_in = S_DONE;
               priority case (req_item.opcode)
                  OP_INSERT: begin
                     if (fill_ff == CNT_W'(TABLE_DEPTH)) begin
                        ovf_in = 1'b1;
                     end else if (fill_ff == '0) begin
                        place_in = '0;
                        state_in = S_PLACE;
                     end else begin
                        issue_in = fill_ff;
                        raddr_in = ADDR_W'(fill_ff - CNT_W'(1));
                        state_in = S_WALK;
                     end
                  end
                  OP_REMOVE, OP_CONTAINS: begin
                     if (fill_ff != '0) begin
                        issue_in = fill_ff;
                        raddr_in = '0;
                        state_in = S_WALK;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_WALK: begin
            if (issue_ff != '0) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = raddr_ff;
               pend_in     = 1'b1;
               pidx_in     = raddr_ff;
               issue_in    = issue_ff - CNT_W'(1);
               raddr_in    = (op_ff == OP_INSERT) ? raddr_ff - ADDR_W'(1)
                                                  : raddr_ff + ADDR_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               priority case (op_ff)
                  OP_INSERT: begin
                     // walk down, shifting larger entries up one slot
                     if (gt) begin
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = pidx_ff + ADDR_W'(1);
                        mem.wr_data = rd_data;
                        if (pidx_ff == '0) begin
                           place_in = '0;
                           pend_in  = 1'b0;
                           state_in = S_PLACE;
                        end
                     end else begin
                        place_in = pidx_ff + ADDR_W'(1);
                        pend_in  = 1'b0;
                        state_in = S_PLACE;
                     end
                  end
                  OP_REMOVE: begin
                     if (!eq) begin
                        mem.wr_en   = 1'b1;
                        mem.wr_addr = wr_ff[ADDR_W-1:0];
                        mem.wr_data = rd_data;
                        wr_in       = wr_ff + CNT_W'(1);
                     end else begin
                        hit_in = 1'b1;
                     end
                     if (last) begin
                        fill_in  = eq ? wr_ff : wr_ff + CNT_W'(1);
                        state_in = S_DONE;
                     end
                  end
                  OP_CONTAINS: begin
                     if (eq) begin
                        hit_in = 1'b1;
                     end
                     if (last) begin
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_PLACE: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = place_ff;
            mem.wr_data = word_ff;
            hit_in      = 1'b1;
            fill_in     = fill_ff + CNT_W'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            done.valid           = 1'b1;
            done.rsp.hit         = hit_ff;
            done.rsp.entry_count = 5'(fill_ff);
            done.rsp.overflow    = ovf_ff;
            state_in             = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      word_ff  <= word_in;
      issue_ff <= issue_in;
      raddr_ff <= raddr_in;
      pidx_ff  <= pidx_in;
      wr_ff    <= wr_in;
      place_ff <= place_in;
      hit_ff   <= hit_in;
      ovf_ff   <= ovf_in;
   end

   assign busy = state_ff != S_IDLE;

endmodule
